[rtl/binary_trie_longest_prefix_match_assert.svh]
// Assertion macros shared by the trie lookup checker.
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define BTLPM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, also while reset is asserted.
`define BTLPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/btlpm_pkg.sv]
// Types and constants of the binary trie longest prefix match block.
`default_nettype none
package btlpm_pkg;

	localparam int NODE_COUNT_DEF = 1024;
	localparam int ADDR_W = 32;
	localparam int LEN_W = 6;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);
	localparam logic [ADDR_W-1:0] FULL_MASK = 32'hFFFF_FFFF;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DUP    = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADLEN = 2'd3
	} res_status_t;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  prefix_length;
		logic [ADDR_W-1:0] owner;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              found;
		logic [ADDR_W-1:0] match_prefix;
		logic [LEN_W-1:0]  match_length;
		logic [ADDR_W-1:0] match_owner;
	} out_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_ALLOC_A,
		S_ALLOC_B,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		logic        load;
		logic        read;
		logic        record;
		logic        descend;
		logic        alloc_a;
		logic        alloc_b;
		logic        write_entry;
		logic        set_status;
		res_status_t status;
		logic        out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_bad_len;
		logic is_insert;
		logic at_limit;
		logic child_zero;
		logic mem_full;
		logic entry_valid;
	} dp_status_t;

endpackage
`default_nettype wire

[rtl/btlpm_ctrl.sv]
// Controller state machine that sequences the trie walk.
`default_nettype none
module btlpm_ctrl
	import btlpm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t dp_st,
	output ctl_cmd_t        cmd
);

	ctl_state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.status = ST_OK;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (dp_st.in_bad_len) begin
						cmd.set_status = 1'b1;
						cmd.status = ST_BADLEN;
						state_d = S_DONE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (!dp_st.is_insert) begin
					cmd.record = 1'b1;
					if (dp_st.at_limit || dp_st.child_zero) begin
						state_d = S_DONE;
					end else begin
						cmd.descend = 1'b1;
						state_d = S_READ;
					end
				end else if (dp_st.at_limit) begin
					cmd.set_status = 1'b1;
					if (dp_st.entry_valid) begin
						cmd.status = ST_DUP;
					end else begin
						cmd.write_entry = 1'b1;
						cmd.status = ST_OK;
					end
					state_d = S_DONE;
				end else if (dp_st.child_zero) begin
					if (dp_st.mem_full) begin
						cmd.set_status = 1'b1;
						cmd.status = ST_FULL;
						state_d = S_DONE;
					end else begin
						state_d = S_ALLOC_A;
					end
				end else begin
					cmd.descend = 1'b1;
					state_d = S_READ;
				end
			end
			S_ALLOC_A: begin
				cmd.alloc_a = 1'b1;
				state_d = S_ALLOC_B;
			end
			S_ALLOC_B: begin
				cmd.alloc_b = 1'b1;
				state_d = S_READ;
			end
			S_DONE: begin
				// The result register is free once its old word is taken.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/btlpm_datapath.sv]
// Node memories, walk registers and result register of the trie.
`default_nettype none
module btlpm_datapath
	import btlpm_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_word_t in_data,
	input  wire ctl_cmd_t cmd,
	output dp_status_t    dp_st,
	output out_word_t     out_data
);

	localparam int NW = $clog2(NODE_COUNT);
	localparam logic [NW:0] NODE_LIMIT = (NW+1)'(NODE_COUNT);

	typedef struct packed {
		logic              valid;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] owner;
	} ent_t;

	logic [NW-1:0] left_mem [NODE_COUNT];
	logic [NW-1:0] right_mem [NODE_COUNT];
	ent_t          ent_mem [NODE_COUNT];

	logic [NW-1:0] left_rd_q, right_rd_q;
	ent_t          ent_rd_q;

	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] owner_q;
	logic [NW-1:0]     node_q;
	logic [LEN_W-1:0]  depth_q;
	logic [NW:0]       next_free_q;
	logic [NW-1:0]     root_left_q, root_right_q;
	logic              best_found_q;
	logic [LEN_W-1:0]  best_len_q;
	logic [ADDR_W-1:0] best_owner_q;
	res_status_t       status_q;
	out_word_t         out_q;

	logic              at_root;
	logic              bit_cur;
	logic [NW-1:0]     left_cur, right_cur, child_cur, new_node;
	logic              entry_valid;
	logic [ADDR_W-1:0] best_mask;

	// The root is never allocated, so its links live in flip-flops cleared by reset.
	// Every other node is cleared when it is allocated, so memories need no reset.
	assign at_root = (node_q == '0);
	assign bit_cur = addr_q[~depth_q[4:0]];
	assign left_cur = at_root ? root_left_q : left_rd_q;
	assign right_cur = at_root ? root_right_q : right_rd_q;
	assign child_cur = bit_cur ? right_cur : left_cur;
	assign entry_valid = !at_root && ent_rd_q.valid;
	assign new_node = next_free_q[NW-1:0];
	assign best_mask = ~(FULL_MASK >> best_len_q);

	always_comb begin
		dp_st.in_bad_len = (in_data.op == OP_INSERT) &&
			((in_data.prefix_length == '0) || (in_data.prefix_length > MAX_LEN));
		dp_st.is_insert = (op_q == OP_INSERT);
		dp_st.at_limit = (op_q == OP_INSERT) ? (depth_q == len_q) : (depth_q == MAX_LEN);
		dp_st.child_zero = (child_cur == '0);
		dp_st.mem_full = (next_free_q == NODE_LIMIT);
		dp_st.entry_valid = entry_valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc_a && bit_cur && !at_root)
			right_mem[node_q] <= new_node;
		else if (cmd.alloc_a && !bit_cur)
			right_mem[new_node] <= '0;
		else if (cmd.alloc_b && bit_cur)
			right_mem[new_node] <= '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc_a && !bit_cur && !at_root)
			left_mem[node_q] <= new_node;
		else if (cmd.alloc_a && bit_cur)
			left_mem[new_node] <= '0;
		else if (cmd.alloc_b && !bit_cur)
			left_mem[new_node] <= '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.write_entry)
			ent_mem[node_q] <= '{valid: 1'b1, len: len_q, owner: owner_q};
		else if (cmd.alloc_b)
			ent_mem[new_node] <= '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			left_rd_q <= left_mem[node_q];
			right_rd_q <= right_mem[node_q];
			ent_rd_q <= ent_mem[node_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= (NW+1)'(1);
			root_left_q <= '0;
			root_right_q <= '0;
		end else begin
			if (cmd.alloc_b)
				next_free_q <= next_free_q + (NW+1)'(1);
			if (cmd.alloc_a && at_root && bit_cur)
				root_right_q <= new_node;
			if (cmd.alloc_a && at_root && !bit_cur)
				root_left_q <= new_node;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_data.op;
			addr_q <= in_data.address;
			len_q <= in_data.prefix_length;
			owner_q <= in_data.owner;
			node_q <= '0;
			depth_q <= '0;
			best_found_q <= 1'b0;
			best_len_q <= '0;
			best_owner_q <= '0;
			status_q <= cmd.set_status ? cmd.status : ST_OK;
		end else begin
			if (cmd.descend) begin
				node_q <= child_cur;
				depth_q <= depth_q + LEN_W'(1);
			end else if (cmd.alloc_b) begin
				node_q <= new_node;
				depth_q <= depth_q + LEN_W'(1);
			end
			if (cmd.record && entry_valid) begin
				best_found_q <= 1'b1;
				best_len_q <= ent_rd_q.len;
				best_owner_q <= ent_rd_q.owner;
			end
			if (cmd.set_status)
				status_q <= cmd.status;
		end
		if (cmd.out_load) begin
			out_q.status <= status_q;
			if (op_q == OP_LOOKUP && best_found_q) begin
				out_q.found <= 1'b1;
				out_q.match_prefix <= addr_q & best_mask;
				out_q.match_length <= best_len_q;
				out_q.match_owner <= best_owner_q;
			end else begin
				out_q.found <= 1'b0;
				out_q.match_prefix <= '0;
				out_q.match_length <= '0;
				out_q.match_owner <= '0;
			end
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

[rtl/binary_trie_longest_prefix_match.sv]
// Top level of the binary trie longest prefix match engine for IPv4.
// An input word (op, address, prefix_length, owner) is taken when in_valid and
// in_ready are both high; each input word yields exactly one output word on
// out_valid/out_ready. A lookup returns the deepest stored prefix on the
// address path; an insert adds a prefix and reports ok, duplicate, full or
// bad length. The walk visits one trie level per node memory read: each level
// goes through a read state and an evaluate state, and each node that an insert
// allocates adds the states ALLOC_A and ALLOC_B. The next word is accepted
// once the walk hands its result to the output register, even while that word
// still waits. A stalled receiver holds the result in the output register; a
// finished walk then waits until it is free. Reset empties the trie at once:
// the root links sit in flip-flops and each other node is cleared when
// allocated, so no clearing pass is needed.
`default_nettype none
module binary_trie_longest_prefix_match
	import btlpm_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_word_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_word_t     out_data
);

	ctl_cmd_t   cmd;
	dp_status_t dp_st;

	btlpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_st     (dp_st),
		.cmd       (cmd)
	);

	btlpm_datapath #(
		.NODE_COUNT (NODE_COUNT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.dp_st    (dp_st),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

[rtl/btlpm_checker.sv]
// Port checker for the trie engine and its bind to the top level.
`default_nettype none
`include "binary_trie_longest_prefix_match_assert.svh"
module btlpm_checker
	import btlpm_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_word_t out_data
);

	`BTLPM_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "output word changed while stalled")
	`BTLPM_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready, "new word accepted while a walk is running")
	`BTLPM_ASSERT(a_found_only_ok, clk, arst_n, out_valid && out_data.found |-> out_data.status == ST_OK && out_data.match_length != '0 && out_data.match_length <= MAX_LEN, "found word with bad status or length")
	`BTLPM_ASSERT(a_miss_zero, clk, arst_n, out_valid && !out_data.found |-> out_data.match_length == '0 && out_data.match_owner == '0 && out_data.match_prefix == '0, "miss word carries match data")

endmodule

bind binary_trie_longest_prefix_match btlpm_checker u_btlpm_checker (.*);
`default_nettype wire

[tb/sv/binary_trie_longest_prefix_match_test.sv]
// Self-checking testbench for the binary trie longest prefix match engine.
`default_nettype none
module binary_trie_longest_prefix_match_test;
	import btlpm_pkg::*;

	localparam int NODES = NODE_COUNT_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_WORDS = 1200;

	class route_table_board;
		logic [9:0]        left_link [NODES];
		logic [9:0]        right_link [NODES];
		logic              has_route [NODES];
		logic [LEN_W-1:0]  route_len [NODES];
		logic [ADDR_W-1:0] route_owner [NODES];
		int                free_node;
		out_word_t         pending [$];
		int                errors, inserts, lookups, hits, full_hits, dups, bad_lens;

		function new();
			for (int i = 0; i < NODES; i++) begin
				left_link[i] = '0;
				right_link[i] = '0;
				has_route[i] = 1'b0;
				route_len[i] = '0;
				route_owner[i] = '0;
			end
			free_node = 1;
		endfunction

		function logic [ADDR_W-1:0] prefix_mask(int len);
			if (len == 0)
				return '0;
			return ~(FULL_MASK >> len);
		endfunction

		function res_status_t add_route(logic [ADDR_W-1:0] addr, int len,
				logic [ADDR_W-1:0] own);
			int node;
			int child;
			logic bit_val;
			node = 0;
			if (len < 1 || len > ADDR_W)
				return ST_BADLEN;
			addr = addr & prefix_mask(len);
			for (int d = 1; d <= len; d++) begin
				bit_val = addr[ADDR_W - d];
				child = bit_val ? right_link[node] : left_link[node];
				if (child == 0) begin
					if (free_node >= NODES)
						return ST_FULL;
					child = free_node;
					free_node++;
					left_link[child] = '0;
					right_link[child] = '0;
					has_route[child] = 1'b0;
					if (bit_val)
						right_link[node] = child[9:0];
					else
						left_link[node] = child[9:0];
				end
				node = child;
			end
			if (has_route[node])
				return ST_DUP;
			has_route[node] = 1'b1;
			route_len[node] = LEN_W'(len);
			route_owner[node] = own;
			return ST_OK;
		endfunction

		function out_word_t best_route(logic [ADDR_W-1:0] addr);
			out_word_t r;
			int node;
			int child;
			r = '0;
			node = 0;
			for (int d = 1; d <= ADDR_W; d++) begin
				child = addr[ADDR_W - d] ? right_link[node] : left_link[node];
				if (child == 0)
					break;
				node = child;
				if (has_route[node]) begin
					r.found = 1'b1;
					r.match_length = route_len[node];
					r.match_owner = route_owner[node];
				end
			end
			if (r.found)
				r.match_prefix = addr & prefix_mask(r.match_length);
			return r;
		endfunction

		function void note_word(in_word_t w);
			out_word_t r;
			r = '0;
			if (w.op == OP_INSERT) begin
				r.status = add_route(w.address, w.prefix_length, w.owner);
				inserts++;
				if (r.status == ST_FULL)
					full_hits++;
				if (r.status == ST_DUP)
					dups++;
				if (r.status == ST_BADLEN)
					bad_lens++;
			end else begin
				r = best_route(w.address);
				lookups++;
				if (r.found)
					hits++;
			end
			pending.push_back(r);
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.found !== want.found) begin
				$display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
				errors++;
			end
			if (got.match_prefix !== want.match_prefix) begin
				$display("%0t: match_prefix expected %h actual %h", $time,
					want.match_prefix, got.match_prefix);
				errors++;
			end
			if (got.match_length !== want.match_length) begin
				$display("%0t: match_length expected %0d actual %0d", $time,
					want.match_length, got.match_length);
				errors++;
			end
			if (got.match_owner !== want.match_owner) begin
				$display("%0t: match_owner expected %h actual %h", $time,
					want.match_owner, got.match_owner);
				errors++;
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	route_table_board board = new();
	int idle_cycles = 0;
	bit no_gaps = 1'b0;
	logic [ADDR_W-1:0] bases [16];

	binary_trie_longest_prefix_match DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_word(in_data);
			if (out_valid && out_ready)
				board.check_word(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// The receiver stalls a random number of cycles before each result word.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 14);
			@(negedge clk);
			out_ready = (stall == 0);
			while (stall > 0) begin
				stall--;
				@(negedge clk);
				out_ready = (stall == 0);
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_word(logic op, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
			logic [ADDR_W-1:0] own);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 14);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_data.op = op;
		in_data.address = addr;
		in_data.prefix_length = len;
		in_data.owner = own;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random_word();
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] noise;
		int len;
		int pick;
		pick = $urandom_range(0, 99);
		noise = $urandom >> $urandom_range(0, 31);
		addr = bases[$urandom_range(0, 15)] ^ noise;
		if (pick < 35) begin
			if ($urandom_range(0, 19) == 0)
				len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 63);
			else if ($urandom_range(0, 3) == 0)
				len = $urandom_range(1, 32);
			else
				len = $urandom_range(1, 14);
			send_word(OP_INSERT, addr, LEN_W'(len), $urandom);
		end else begin
			if (pick > 90)
				addr = $urandom;
			send_word(OP_LOOKUP, addr, LEN_W'($urandom), $urandom);
		end
	endtask

	initial begin
		for (int i = 0; i < 16; i++)
			bases[i] = $urandom;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty trie, zero prefixes, all-ones host route, unmasked and bad lengths.
		send_word(OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0);
		send_word(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
		send_word(OP_INSERT, 32'h0000_0000, 6'd8, 32'h0000_0001);
		send_word(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
		send_word(OP_INSERT, 32'h0A01_0203, 6'd8, 32'h1234_5678);
		send_word(OP_INSERT, 32'h0AFF_FFFF, 6'd8, 32'hDEAD_BEEF);
		send_word(OP_INSERT, 32'h0A01_0000, 6'd16, 32'h0000_00AA);
		send_word(OP_INSERT, 32'h8000_0000, 6'd0, 32'h5555_5555);
		send_word(OP_INSERT, 32'h8000_0000, 6'd33, 32'hAAAA_AAAA);
		send_word(OP_INSERT, 32'hFFFF_FFFF, 6'd63, 32'h1);
		send_word(OP_INSERT, 32'hFFFF_FFFF, 6'd1, 32'h8000_0000);
		send_word(OP_INSERT, 32'h7FFF_FFFF, 6'd1, 32'h0000_0002);
		send_word(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'h0);
		send_word(OP_LOOKUP, 32'h0005_0505, 6'd0, 32'h0);
		send_word(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
		send_word(OP_LOOKUP, 32'hFFFF_FFFE, 6'd0, 32'h0);
		send_word(OP_LOOKUP, 32'h0A09_0909, 6'd0, 32'h0);
		send_word(OP_LOOKUP, 32'h0A01_FFFF, 6'd0, 32'h0);
		send_word(OP_LOOKUP, 32'h7FFF_FFFF, 6'd0, 32'h0);
		send_word(OP_LOOKUP, 32'h8000_0001, 6'd0, 32'h0);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 60 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			send_random_word();
		end
		@(negedge clk);
		in_valid = 1'b0;
		no_gaps = 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Covered %0d inserts (%0d duplicate, %0d full, %0d bad length) and %0d lookups",
			board.inserts, board.dups, board.full_hits, board.bad_lens, board.lookups);
		$display("with %0d hits; %0d of %0d nodes used.", board.hits, board.free_node, NODES);
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
